[hw/rtl/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Opcodes, status and order codes, default sizes and the cell control bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEFAULT_CAPACITY       = 16;
    localparam int DEFAULT_VALUE_WIDTH    = 32;
    localparam int DEFAULT_PRIORITY_WIDTH = 32;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_TOP  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] ORD_LE = 2'd0;
    localparam logic [1:0] ORD_LT = 2'd1;
    localparam logic [1:0] ORD_GE = 2'd2;
    localparam logic [1:0] ORD_GT = 2'd3;

    // control broadcast to every cell in the chain
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [1:0] order_mode;
    } cell_ctrl_t;

endpackage

[hw/rtl/spq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one value/priority pair, compares it against the pushed priority and
// shifts toward the tail on insert or toward the head on pop.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int VALUE_WIDTH    = spq_pkg::DEFAULT_VALUE_WIDTH,
    parameter int PRIORITY_WIDTH = spq_pkg::DEFAULT_PRIORITY_WIDTH
) (
    input  logic                      clk,
    input  spq_pkg::cell_ctrl_t       ctrl,
    input  logic                      occupied,
    input  logic                      is_tail,
    input  logic [VALUE_WIDTH-1:0]    new_value,
    input  logic [PRIORITY_WIDTH-1:0] new_priority,
    input  logic                      match_in,
    output logic                      match_out,
    input  logic [VALUE_WIDTH-1:0]    left_value,
    input  logic [PRIORITY_WIDTH-1:0] left_priority,
    input  logic [VALUE_WIDTH-1:0]    right_value,
    input  logic [PRIORITY_WIDTH-1:0] right_priority,
    output logic [VALUE_WIDTH-1:0]    value,
    output logic [PRIORITY_WIDTH-1:0] priority_q
);

    logic [VALUE_WIDTH-1:0]    value_reg;
    logic [VALUE_WIDTH-1:0]    value_next;
    logic [PRIORITY_WIDTH-1:0] priority_reg;
    logic [PRIORITY_WIDTH-1:0] priority_next;
    logic                      rel_holds;
    logic                      match_here;

    always_comb
    begin
        unique case (ctrl.order_mode)
            spq_pkg::ORD_LE: rel_holds = $signed(new_priority) <= $signed(priority_reg);
            spq_pkg::ORD_LT: rel_holds = $signed(new_priority) <  $signed(priority_reg);
            spq_pkg::ORD_GE: rel_holds = $signed(new_priority) >= $signed(priority_reg);
            default:         rel_holds = $signed(new_priority) >  $signed(priority_reg);
        endcase
    end

    assign match_here = occupied & rel_holds;
    // tell the tail side that the insert point lies here or closer to the head
    assign match_out  = match_in | match_here;

    always_comb
    begin
        value_next    = value_reg;
        priority_next = priority_reg;
        priority if (ctrl.push)
        begin
            if (match_in)
            begin
                value_next    = left_value;
                priority_next = left_priority;
            end
            else if (match_here || is_tail)
            begin
                value_next    = new_value;
                priority_next = new_priority;
            end
        end
        else if (ctrl.pop)
        begin
            value_next    = right_value;
            priority_next = right_priority;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        priority_reg <= priority_next;
    end

    assign value      = value_reg;
    assign priority_q = priority_reg;

endmodule

[hw/rtl/sorted_priority_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: bounded priority queue kept as a sorted chain
//
// Commands enter on start/opcode/item_value/item_priority and are taken at
// any edge with start high; busy stays low, since every command finishes in
// the cycle it is taken. Opcodes: push, pop, top. A push is placed before the
// first stored entry such that the new priority stands in the order_mode
// relation to that entry's priority, otherwise at the tail.
// Each item gives one result in the cycle after it is taken: done pulses for one
// cycle with out_value, out_priority, status, occupancy and is_empty. Throughput
// is one command per cycle, set by the chain of cells that all compare and
// shift in the same cycle; the one-bit insert-point chain across the cells is
// the long path. The receiver cannot stall, so results are never held.
// The user must write order_mode (cfg_we/cfg_data) only while no command is in
// flight; the block itself does not enforce this. Reset empties the queue, sets
// order_mode to less-or-equal and clears the occupancy count but not cell contents.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
    parameter int CAPACITY       = spq_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_WIDTH    = spq_pkg::DEFAULT_VALUE_WIDTH,
    parameter int PRIORITY_WIDTH = spq_pkg::DEFAULT_PRIORITY_WIDTH,
    localparam int CW            = $clog2(CAPACITY + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_data,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                opcode,
    input  logic [VALUE_WIDTH-1:0]    item_value,
    input  logic [PRIORITY_WIDTH-1:0] item_priority,
    output logic                      done,
    output logic [VALUE_WIDTH-1:0]    out_value,
    output logic [PRIORITY_WIDTH-1:0] out_priority,
    output logic [1:0]                status,
    output logic [CW-1:0]             occupancy,
    output logic                      is_empty
);

    logic [1:0]    order_mode_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;

    logic [VALUE_WIDTH-1:0]    out_value_reg;
    logic [VALUE_WIDTH-1:0]    out_value_next;
    logic [PRIORITY_WIDTH-1:0] out_priority_reg;
    logic [PRIORITY_WIDTH-1:0] out_priority_next;
    logic [1:0]                status_reg;
    logic [1:0]                status_next;

    logic accept;
    logic full;
    logic empty;
    spq_pkg::cell_ctrl_t ctrl;

    logic [VALUE_WIDTH-1:0]    cell_value    [CAPACITY];
    logic [PRIORITY_WIDTH-1:0] cell_priority [CAPACITY];
    logic [CAPACITY:0]         match_chain;

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign full   = (count_reg == CW'(CAPACITY));
    assign empty  = (count_reg == '0);

    assign ctrl.push       = accept && (opcode == spq_pkg::OP_PUSH) && !full;
    assign ctrl.pop        = accept && (opcode == spq_pkg::OP_POP) && !empty;
    assign ctrl.order_mode = order_mode_reg;

    assign match_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0]    lv;
        logic [PRIORITY_WIDTH-1:0] lp;
        logic [VALUE_WIDTH-1:0]    rv;
        logic [PRIORITY_WIDTH-1:0] rp;

        if (i == 0)
        begin : g_head
            assign lv = item_value;
            assign lp = item_priority;
        end
        else
        begin : g_mid
            assign lv = cell_value[i-1];
            assign lp = cell_priority[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rv = '0;
            assign rp = '0;
        end
        else
        begin : g_inner
            assign rv = cell_value[i+1];
            assign rp = cell_priority[i+1];
        end

        spq_cell #(
            .VALUE_WIDTH    (VALUE_WIDTH),
            .PRIORITY_WIDTH (PRIORITY_WIDTH)
        ) u_cell (
            .clk            (clk),
            .ctrl           (ctrl),
            .occupied       (CW'(i) < count_reg),
            .is_tail        (CW'(i) == count_reg),
            .new_value      (item_value),
            .new_priority   (item_priority),
            .match_in       (match_chain[i]),
            .match_out      (match_chain[i+1]),
            .left_value     (lv),
            .left_priority  (lp),
            .right_value    (rv),
            .right_priority (rp),
            .value          (cell_value[i]),
            .priority_q     (cell_priority[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        out_value_next    = '0;
        out_priority_next = '0;
        status_next       = spq_pkg::ST_OK;
        unique case (opcode)
            spq_pkg::OP_PUSH:
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
            end
            spq_pkg::OP_POP, spq_pkg::OP_TOP:
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    out_value_next    = cell_value[0];
                    out_priority_next = cell_priority[0];
                end
            end
            default:
            begin
                status_next = spq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= spq_pkg::ORD_LE;
            count_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                order_mode_reg <= cfg_data;
            end
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // result payload: hold the last item's values between strobes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg    <= out_value_next;
            out_priority_reg <= out_priority_next;
            status_reg       <= status_next;
        end
    end

    assign done         = done_reg;
    assign out_value    = out_value_reg;
    assign out_priority = out_priority_reg;
    assign status       = status_reg;
    assign occupancy    = count_reg;
    assign is_empty     = (count_reg == '0);

endmodule

[hw/rtl/spq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker #(
    parameter int CAPACITY       = spq_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_WIDTH    = spq_pkg::DEFAULT_VALUE_WIDTH,
    parameter int PRIORITY_WIDTH = spq_pkg::DEFAULT_PRIORITY_WIDTH,
    localparam int CW            = $clog2(CAPACITY + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [1:0]                opcode,
    input  logic                      done,
    input  logic [VALUE_WIDTH-1:0]    out_value,
    input  logic [PRIORITY_WIDTH-1:0] out_priority,
    input  logic [1:0]                status,
    input  logic [CW-1:0]             occupancy,
    input  logic                      is_empty
);

    // every accepted item gives exactly one strobe on the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted item without result strobe");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result strobe without accepted item");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (occupancy <= CW'(CAPACITY)) && (is_empty == (occupancy == '0)))
        else $error("occupancy out of range or empty flag wrong");

    // a failed pop or top leaves an empty queue and returns zeros
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == spq_pkg::ST_EMPTY)
            |-> (is_empty && out_value == '0 && out_priority == '0))
        else $error("empty status with data or entries");

    // a successful push grows the queue by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == spq_pkg::OP_PUSH && occupancy != CW'(CAPACITY))
            |=> (occupancy == $past(occupancy) + CW'(1)))
        else $error("push did not grow occupancy");

endmodule

bind sorted_priority_queue_core spq_checker #(
    .CAPACITY       (CAPACITY),
    .VALUE_WIDTH    (VALUE_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
) u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .done         (done),
    .out_value    (out_value),
    .out_priority (out_priority),
    .status       (status),
    .occupancy    (occupancy),
    .is_empty     (is_empty)
);
